@@ design/sdspi_pkg.sv @@
// sdspi_pkg: shared types and constants for the sd card spi host sequencer
// no dependencies
`default_nettype none
package sdspi_pkg;

   typedef enum logic [2:0] {
      OP_CARD_BYTE = 3'd0,
      OP_INIT      = 3'd1,
      OP_READ      = 3'd2,
      OP_WRITE     = 3'd3,
      OP_HOST_BYTE = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_BUSY     = 3'd0,
      ST_OK       = 3'd1,
      ST_CMD0_BAD = 3'd2,
      ST_CMD8_BAD = 3'd3,
      ST_TIMEOUT  = 3'd4,
      ST_NO_POWER = 3'd5,
      ST_NOT_RDY  = 3'd6,
      ST_WR_REJ   = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      P_IDLE, P_DUMMY, P_CMD_TX, P_R1_POLL, P_TAIL, P_CSD_TOKEN, P_CSD_DATA,
      P_RD_READY, P_RD_TOKEN, P_RD_DATA, P_WR_READY, P_WR_PAD, P_WR_TOKEN,
      P_WR_HOST, P_WR_XCHG, P_WR_RESP
   } phase_type;

   localparam logic [1:0] CSR_RESET_REPEATS = 2'd0;
   localparam logic [1:0] CSR_RETRY_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_POLL_LIMIT    = 2'd2;
   localparam logic [1:0] CSR_DUMMY_BYTES   = 2'd3;

   localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
   localparam logic [5:0] CMD_IF_COND   = 6'd8;
   localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
   localparam logic [5:0] CMD_RD_SINGLE = 6'd17;
   localparam logic [5:0] CMD_WR_SINGLE = 6'd24;
   localparam logic [5:0] CMD_SEND_OP   = 6'd41;
   localparam logic [5:0] CMD_APP       = 6'd55;
   localparam logic [5:0] CMD_READ_OCR  = 6'd58;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] block_number;
      logic [7:0]  byte_in;
   } req_type;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        tx_valid;
      logic        select_low;
      logic        fast_clock;
      logic [7:0]  read_byte;
      logic        read_valid;
      logic        read_last;
      logic        wants_host_byte;
      logic        done_res;
      logic [2:0]  status;
      logic        card_ready;
      logic [33:0] last_block_address;
   } rsp_type;

   typedef struct packed {
      logic [1:0] reset_repeats;
      logic [9:0] init_retry_limit;
      logic [3:0] response_poll_limit;
      logic [4:0] dummy_clock_bytes;
   } cfg_type;

endpackage
`default_nettype wire

@@ design/sdspi_csr.sv @@
// sdspi_csr: configuration registers of the sd spi sequencer
// depends on sdspi_pkg
`default_nettype none
module sdspi_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [9:0]        csr_data,
   output sdspi_pkg::cfg_type     cfg
);
   sdspi_pkg::cfg_type cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_repeats       <= 2'd2;
         cfg_ff.init_retry_limit    <= 10'd800;
         cfg_ff.response_poll_limit <= 4'd8;
         cfg_ff.dummy_clock_bytes   <= 5'd11;
      end else if (csr_write) begin
         unique case (csr_index)
            sdspi_pkg::CSR_RESET_REPEATS: cfg_ff.reset_repeats <= csr_data[1:0];
            sdspi_pkg::CSR_RETRY_LIMIT:   cfg_ff.init_retry_limit <= csr_data;
            sdspi_pkg::CSR_POLL_LIMIT:    cfg_ff.response_poll_limit <= csr_data[3:0];
            default:                      cfg_ff.dummy_clock_bytes <= csr_data[4:0];
         endcase
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

@@ design/sd_card_spi_host_sequencer.sv @@
// sd_card_spi_host_sequencer: top level, byte-level sd spi-mode sequencer
// depends on sdspi_pkg and sdspi_csr
//
// Usage: every item on req_ is one request. Operation 0 carries the card byte
// received for the last byte sent; the block answers with the next byte to
// shift out (tx_byte/tx_valid) and with read data, status and flags on rsp_.
// Operations 1, 2 and 3 start init, a block read and a block write; operation
// 4 carries a host data byte while wants_host_byte was set. Items that mean
// nothing in the current phase are taken and give no result.
// Flow: the result register is loaded from the accepted item; one item may be
// accepted every cycle while the result register is empty or being emptied, as
// the state update runs combinationally from the request to the result register.
// In a system each item is one SPI byte exchange.
// Reset: synchronous, returns to idle with no ready card and slow clock;
// control registers take their reset values; frame and payload registers are not reset.
// Stall: while rsp_ready is low the result is held; a new item is taken only
// when the result register is empty or being emptied in the same cycle.
// Configuration must be written through csr_ only while idle; the block does not enforce it.
`default_nettype none
module sd_card_spi_host_sequencer #(
   parameter int BLOCK_BYTES = 512
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire sdspi_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output sdspi_pkg::rsp_type      rsp_data,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [9:0]         csr_data
);
   localparam int RunBytes = BLOCK_BYTES + 2;
   localparam int CntW = $clog2(RunBytes + 1);

   sdspi_pkg::cfg_type cfg;
   sdspi_csr u_csr (
      .clock(clock), .reset(reset), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data), .cfg(cfg)
   );

   sdspi_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  cmd_ff [6];
   logic [7:0]  cmd_in [6];
   logic [7:0]  resp_ff [5];
   logic [7:0]  resp_in [5];
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [1:0]  rst_cnt_ff, rst_cnt_in;
   logic [9:0]  retry_ff, retry_in;
   logic [23:0] size_ff, size_in;
   logic [31:0] target_ff, target_in;
   logic        ready_ff, ready_in, speed_ff, speed_in;
   logic        rsp_valid_ff, made;
   sdspi_pkg::rsp_type rsp_ff, r;

   logic [7:0]  b;
   logic [1:0]  rep_eff;
   logic [3:0]  poll_eff;
   logic [4:0]  dummy_eff;
   logic [5:0]  cur_cmd;
   logic        take;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take = req_valid && req_ready;
   assign b = req_data.byte_in;
   assign rep_eff = (cfg.reset_repeats == 2'd0) ? 2'd1 : cfg.reset_repeats;
   assign poll_eff = (cfg.response_poll_limit == 4'd0) ? 4'd1 : cfg.response_poll_limit;
   assign dummy_eff = (cfg.dummy_clock_bytes == 5'd0) ? 5'd1 : cfg.dummy_clock_bytes;
   assign cur_cmd = cmd_ff[0][5:0];

   // next state and result for one item
   always_comb begin
      logic [5:0]  ci;
      logic [31:0] ca;
      logic [7:0]  cc;
      logic        go_cmd;
      logic [CntW-1:0] cinc;
      phase_in = phase_ff;
      cmd_in = cmd_ff;
      resp_in = resp_ff;
      cnt_in = cnt_ff;
      rst_cnt_in = rst_cnt_ff;
      retry_in = retry_ff;
      size_in = size_ff;
      target_in = target_ff;
      ready_in = ready_ff;
      speed_in = speed_ff;
      r = '0;
      made = 1'b0;
      go_cmd = 1'b0;
      ci = '0;
      ca = '0;
      cc = '0;
      cinc = cnt_ff + 1'b1;
      unique case (sdspi_pkg::op_type'(req_data.operation))
         sdspi_pkg::OP_CARD_BYTE: begin
            made = 1'b1;
            unique case (phase_ff)
               sdspi_pkg::P_DUMMY: begin
                  if (cnt_ff < CntW'(dummy_eff)) begin
                     cnt_in = cinc; r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                  end else begin
                     go_cmd = 1'b1; ci = sdspi_pkg::CMD_GO_IDLE; cc = 8'h95;
                  end
               end
               sdspi_pkg::P_CMD_TX: begin
                  if (cnt_ff < CntW'(6)) begin
                     r.tx_byte = cmd_ff[cnt_ff[2:0]]; r.tx_valid = 1'b1; cnt_in = cinc;
                  end else begin
                     phase_in = sdspi_pkg::P_R1_POLL; cnt_in = CntW'(1);
                     r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                  end
               end
               sdspi_pkg::P_R1_POLL: begin
                  if (!b[7] || cnt_ff >= CntW'(poll_eff)) begin
                     resp_in[0] = b;
                     priority case (cur_cmd)
                        sdspi_pkg::CMD_GO_IDLE: begin
                           if (b != 8'h01) begin
                              phase_in = sdspi_pkg::P_IDLE; r.done_res = 1'b1;
                              r.status = sdspi_pkg::ST_CMD0_BAD;
                           end else begin
                              rst_cnt_in = rst_cnt_ff + 2'd1;
                              if (rst_cnt_in < rep_eff) begin
                                 phase_in = sdspi_pkg::P_DUMMY; cnt_in = CntW'(1);
                                 r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                              end else begin
                                 go_cmd = 1'b1; ci = sdspi_pkg::CMD_IF_COND;
                                 ca = 32'h0000_01AA; cc = 8'h87;
                              end
                           end
                        end
                        sdspi_pkg::CMD_IF_COND, sdspi_pkg::CMD_READ_OCR: begin
                           phase_in = sdspi_pkg::P_TAIL; cnt_in = CntW'(1);
                           r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                        end
                        sdspi_pkg::CMD_APP: begin
                           go_cmd = 1'b1; ci = sdspi_pkg::CMD_SEND_OP; ca = 32'h4000_0000;
                        end
                        sdspi_pkg::CMD_SEND_OP: begin
                           if (b == 8'h00) begin
                              go_cmd = 1'b1; ci = sdspi_pkg::CMD_READ_OCR;
                              ca = 32'h5800_0000;
                           end else if (retry_ff < cfg.init_retry_limit) begin
                              retry_in = retry_ff + 10'd1;
                              go_cmd = 1'b1; ci = sdspi_pkg::CMD_APP;
                           end else begin
                              phase_in = sdspi_pkg::P_IDLE; r.done_res = 1'b1;
                              r.status = sdspi_pkg::ST_TIMEOUT;
                           end
                        end
                        sdspi_pkg::CMD_RD_SINGLE: begin
                           if (b[7:1] != 7'd0) begin
                              go_cmd = 1'b1; ci = sdspi_pkg::CMD_RD_SINGLE; ca = target_ff;
                           end else begin
                              phase_in = sdspi_pkg::P_RD_TOKEN;
                              r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                           end
                        end
                        sdspi_pkg::CMD_WR_SINGLE: begin
                           if (b != 8'h00) begin
                              go_cmd = 1'b1; ci = sdspi_pkg::CMD_WR_SINGLE; ca = target_ff;
                           end else begin
                              phase_in = sdspi_pkg::P_WR_TOKEN; cnt_in = CntW'(1);
                              r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                           end
                        end
                        default: begin
                           phase_in = sdspi_pkg::P_CSD_TOKEN;
                           r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                        end
                     endcase
                  end else begin
                     cnt_in = cinc; r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                  end
               end
               sdspi_pkg::P_TAIL: begin
                  if (cnt_ff >= CntW'(1) && cnt_ff <= CntW'(4))
                     resp_in[cnt_ff[2:0]] = b;
                  if (cnt_ff < CntW'(4)) begin
                     cnt_in = cinc; r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                  end else if (cur_cmd == sdspi_pkg::CMD_IF_COND) begin
                     // byte 4 is the current input
                     if (resp_ff[3] == 8'h01 && b == 8'hAA) begin
                        go_cmd = 1'b1; ci = sdspi_pkg::CMD_APP;
                     end else begin
                        phase_in = sdspi_pkg::P_IDLE; r.done_res = 1'b1;
                        r.status = sdspi_pkg::ST_CMD8_BAD;
                     end
                  end else if (resp_ff[1][7]) begin
                     speed_in = 1'b1; go_cmd = 1'b1; ci = sdspi_pkg::CMD_SEND_CSD;
                  end else begin
                     phase_in = sdspi_pkg::P_IDLE; r.done_res = 1'b1;
                     r.status = sdspi_pkg::ST_NO_POWER;
                  end
               end
               sdspi_pkg::P_CSD_TOKEN, sdspi_pkg::P_RD_TOKEN: begin
                  if (b != 8'hFF) begin
                     phase_in = (phase_ff == sdspi_pkg::P_CSD_TOKEN) ?
                                sdspi_pkg::P_CSD_DATA : sdspi_pkg::P_RD_DATA;
                     cnt_in = '0;
                  end
                  r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
               end
               sdspi_pkg::P_CSD_DATA: begin
                  if (cnt_ff == CntW'(7)) size_in = {16'd0, b};
                  else if (cnt_ff == CntW'(8) || cnt_ff == CntW'(9))
                     size_in = {size_ff[15:0], b};
                  cnt_in = cinc;
                  if (cinc >= CntW'(18)) begin
                     ready_in = 1'b1; phase_in = sdspi_pkg::P_IDLE;
                     r.done_res = 1'b1; r.status = sdspi_pkg::ST_OK;
                  end else begin
                     r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                  end
               end
               sdspi_pkg::P_RD_READY: begin
                  if (b == 8'h00) begin
                     r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                  end else begin
                     go_cmd = 1'b1; ci = sdspi_pkg::CMD_RD_SINGLE; ca = target_ff;
                  end
               end
               sdspi_pkg::P_RD_DATA: begin
                  r.read_byte = b; r.read_valid = 1'b1; cnt_in = cinc;
                  if (cinc >= CntW'(RunBytes)) begin
                     r.read_last = 1'b1; phase_in = sdspi_pkg::P_IDLE;
                     r.done_res = 1'b1; r.status = sdspi_pkg::ST_OK;
                  end else begin
                     r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                  end
               end
               sdspi_pkg::P_WR_READY: begin
                  if (b != 8'h00) begin
                     phase_in = sdspi_pkg::P_WR_PAD; cnt_in = CntW'(1);
                  end
                  r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
               end
               sdspi_pkg::P_WR_PAD: begin
                  if (cnt_ff < CntW'(3)) begin
                     cnt_in = cinc; r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                  end else begin
                     go_cmd = 1'b1; ci = sdspi_pkg::CMD_WR_SINGLE; ca = target_ff;
                  end
               end
               sdspi_pkg::P_WR_TOKEN: begin
                  if (cnt_ff == CntW'(1)) begin
                     cnt_in = CntW'(2); r.tx_byte = 8'hFE; r.tx_valid = 1'b1;
                  end else begin
                     phase_in = sdspi_pkg::P_WR_HOST; cnt_in = '0;
                     r.wants_host_byte = 1'b1;
                  end
               end
               sdspi_pkg::P_WR_XCHG: begin
                  if (cnt_ff < CntW'(RunBytes)) begin
                     phase_in = sdspi_pkg::P_WR_HOST; r.wants_host_byte = 1'b1;
                  end else begin
                     phase_in = sdspi_pkg::P_WR_RESP;
                     r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                  end
               end
               sdspi_pkg::P_WR_RESP: begin
                  if (b == 8'hFF) begin
                     r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                  end else begin
                     phase_in = sdspi_pkg::P_IDLE; r.done_res = 1'b1;
                     r.status = (b[3:0] == 4'b0101) ? sdspi_pkg::ST_OK
                                                    : sdspi_pkg::ST_WR_REJ;
                  end
               end
               default: made = 1'b0;
            endcase
         end
         sdspi_pkg::OP_INIT: begin
            if (phase_ff == sdspi_pkg::P_IDLE) begin
               made = 1'b1; ready_in = 1'b0; speed_in = 1'b0;
               rst_cnt_in = '0; retry_in = '0;
               phase_in = sdspi_pkg::P_DUMMY; cnt_in = CntW'(1);
               r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
            end
         end
         sdspi_pkg::OP_READ, sdspi_pkg::OP_WRITE: begin
            if (phase_ff == sdspi_pkg::P_IDLE) begin
               made = 1'b1;
               if (!ready_ff) begin
                  r.done_res = 1'b1; r.status = sdspi_pkg::ST_NOT_RDY;
               end else begin
                  target_in = req_data.block_number;
                  phase_in = (req_data.operation == sdspi_pkg::OP_READ) ?
                             sdspi_pkg::P_RD_READY : sdspi_pkg::P_WR_READY;
                  r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
               end
            end
         end
         sdspi_pkg::OP_HOST_BYTE: begin
            if (phase_ff == sdspi_pkg::P_WR_HOST) begin
               made = 1'b1; r.tx_byte = b; r.tx_valid = 1'b1;
               cnt_in = cinc; phase_in = sdspi_pkg::P_WR_XCHG;
            end
         end
         default: made = 1'b0;
      endcase
      // load a command frame and send its first byte
      if (go_cmd) begin
         cmd_in[0] = {2'b01, ci};
         cmd_in[1] = ca[31:24];
         cmd_in[2] = ca[23:16];
         cmd_in[3] = ca[15:8];
         cmd_in[4] = ca[7:0];
         cmd_in[5] = cc;
         phase_in = sdspi_pkg::P_CMD_TX;
         cnt_in = CntW'(1);
         r.tx_byte = {2'b01, ci};
         r.tx_valid = 1'b1;
      end
      r.select_low = !(phase_in == sdspi_pkg::P_DUMMY ||
                       (phase_in == sdspi_pkg::P_IDLE && !ready_in));
      r.fast_clock = speed_in;
      r.card_ready = ready_in;
      r.last_block_address = ready_in ? {size_in, 10'h3FF} : 34'd0;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sdspi_pkg::P_IDLE;
         cnt_ff <= '0;
         rst_cnt_ff <= '0;
         retry_ff <= '0;
         size_ff <= '0;
         target_ff <= '0;
         ready_ff <= 1'b0;
         speed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in;
            cnt_ff <= cnt_in;
            rst_cnt_ff <= rst_cnt_in;
            retry_ff <= retry_in;
            size_ff <= size_in;
            target_ff <= target_in;
            ready_ff <= ready_in;
            speed_ff <= speed_in;
         end
         if (take) rsp_valid_ff <= made;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // frame bytes and result payload
   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
         resp_ff <= resp_in;
         rsp_ff <= r;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire
